/* rtl/ism_pkg.sv */
// shared types and constants of the ising lattice block
package ism_pkg;

	// lattice side, default
	localparam int GRID_SIDE_DEF = 64;

	// fixed field widths
	localparam int COORD_IN_W = 6;
	localparam int DRAW_W     = 32;
	localparam int BOND_OUT_W = 15;
	localparam int MAG_OUT_W  = 14;
	localparam int SWEEP_W    = 32;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// command codes
	localparam logic CMD_TRIAL = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// coupling modes
	localparam logic [MODE_W-1:0] MODE_FERRO = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ANTI  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ZERO  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TH_SMALL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TH_LARGE = 2'd2;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = 2;

	// classified command as it sits in the queue
	typedef struct packed {
		logic                  cmd;
		logic [COORD_IN_W-1:0] row;
		logic [COORD_IN_W-1:0] col;
		logic                  row_first;
		logic                  row_last;
		logic                  col_first;
		logic                  col_last;
		logic [DRAW_W-1:0]     draw;
	} ism_entry_t;

	// queue status seen by the front
	typedef struct packed {
		logic full;
		logic empty;
	} ism_qstat_t;

endpackage

/* rtl/ism_front.sv */
// front end: input handshake, coordinate clamp and edge classification
module ism_front #(
	parameter int GRID_SIDE = ism_pkg::GRID_SIDE_DEF
) (
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            command,
	input  logic [ism_pkg::COORD_IN_W-1:0]  row,
	input  logic [ism_pkg::COORD_IN_W-1:0]  col,
	input  logic [ism_pkg::DRAW_W-1:0]      random_draw,
	input  logic                            clearing,
	input  ism_pkg::ism_qstat_t             qstat,
	output logic                            push,
	output ism_pkg::ism_entry_t             push_entry
);
	import ism_pkg::*;

	localparam int LAST_IDX = GRID_SIDE - 1;
	localparam logic [COORD_IN_W-1:0] EDGE_IN =
		(LAST_IDX > 63) ? 6'd63 : COORD_IN_W'(LAST_IDX);

	logic [COORD_IN_W-1:0] row_cl;
	logic [COORD_IN_W-1:0] col_cl;

	// take items while the queue has room and the lattice is initialized
	assign in_ready = !qstat.full && !clearing;
	assign push     = in_valid && in_ready;

	// clamp coordinates past the side
	assign row_cl = (row > EDGE_IN) ? EDGE_IN : row;
	assign col_cl = (col > EDGE_IN) ? EDGE_IN : col;

	// classify wrap-around edges for the neighbor addressing
	always_comb begin
		push_entry.cmd       = command;
		push_entry.row       = row_cl;
		push_entry.col       = col_cl;
		push_entry.row_first = (row_cl == '0);
		push_entry.row_last  = (32'(row_cl) == 32'(LAST_IDX));
		push_entry.col_first = (col_cl == '0);
		push_entry.col_last  = (32'(col_cl) == 32'(LAST_IDX));
		push_entry.draw      = random_draw;
	end

endmodule

/* rtl/ism_queue.sv */
// short command queue between the front and back ends
module ism_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ism_pkg::ism_entry_t  push_entry,
	input  logic                 pop,
	output ism_pkg::ism_entry_t  head,
	output ism_pkg::ism_qstat_t  qstat
);
	import ism_pkg::*;

	ism_entry_t             slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign qstat.full  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QUEUE_PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= QUEUE_PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= QUEUE_CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= QUEUE_CNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

/* rtl/ism_back.sv */
// back end: spin memory, metropolis decision, running sums and result register
module ism_back #(
	parameter int GRID_SIDE = ism_pkg::GRID_SIDE_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ism_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ism_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  ism_pkg::ism_entry_t                   head,
	input  ism_pkg::ism_qstat_t                   qstat,
	output logic                                  pop,
	output logic                                  clearing,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  spin_bit,
	output logic                                  flipped,
	output logic signed [ism_pkg::BOND_OUT_W-1:0] bond_sum,
	output logic signed [ism_pkg::MAG_OUT_W-1:0]  magnetization_sum,
	output logic [ism_pkg::SWEEP_W-1:0]           sweep_count
);
	import ism_pkg::*;

	localparam int CW       = $clog2(GRID_SIDE);
	localparam int SITES    = GRID_SIDE * GRID_SIDE;
	localparam int TC_W     = $clog2(SITES);
	localparam int BOND_RAW = $clog2(2 * SITES + 1) + 1;
	localparam int BOND_W   = (BOND_RAW > BOND_OUT_W) ? BOND_RAW : BOND_OUT_W;
	localparam int MAG_RAW  = $clog2(SITES + 1) + 1;
	localparam int MAG_W    = (MAG_RAW > MAG_OUT_W) ? MAG_RAW : MAG_OUT_W;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_FETCH  = 4'b0010,
		ST_GATHER = 4'b0100,
		ST_EXEC   = 4'b1000
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         clr_row_q;
	ism_entry_t            entry_q;
	logic [GRID_SIDE-1:0]  spin_mem [GRID_SIDE];
	logic [GRID_SIDE-1:0]  rd_a_q;
	logic [GRID_SIDE-1:0]  rd_b_q;
	logic [GRID_SIDE-1:0]  up_row_q;
	logic [MODE_W-1:0]     mode_q;
	logic [DRAW_W-1:0]     th_small_q;
	logic [DRAW_W-1:0]     th_large_q;
	logic [BOND_W-1:0]     bond_q;
	logic [MAG_W-1:0]      mag_q;
	logic [TC_W-1:0]       trial_q;
	logic [SWEEP_W-1:0]    sweep_q;
	logic                  out_valid_q;
	logic                  spin_out_q;
	logic                  flip_out_q;
	logic [BOND_OUT_W-1:0] bond_out_q;
	logic [MAG_OUT_W-1:0]  mag_out_q;
	logic [SWEEP_W-1:0]    sweep_out_q;

	logic [CW-1:0]         head_row;
	logic [CW-1:0]         head_up;
	logic [CW-1:0]         e_row;
	logic [CW-1:0]         e_col;
	logic [CW-1:0]         e_down;
	logic [CW-1:0]         e_left;
	logic [CW-1:0]         e_right;
	logic                  rd_a_en;
	logic                  rd_b_en;
	logic [CW-1:0]         rd_b_addr;
	logic                  mem_we;
	logic [CW-1:0]         mem_waddr;
	logic [GRID_SIDE-1:0]  mem_wdata;
	logic                  s_bit;
	logic [2:0]            eq_cnt;
	logic                  is_trial;
	logic                  uphill;
	logic                  big_step;
	logic                  flip;
	logic                  exec_go;
	logic [BOND_W-1:0]     bond_nx;
	logic [MAG_W-1:0]      mag_nx;
	logic [TC_W-1:0]       trial_nx;
	logic [SWEEP_W-1:0]    sweep_nx;

	assign clearing = (state_q == ST_CLEAR);
	assign pop      = (state_q == ST_FETCH) && !qstat.empty;
	assign exec_go  = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	// neighbor row and column addresses with wrap-around
	assign head_row = CW'(head.row);
	assign head_up  = head.row_first ? CW'(GRID_SIDE - 1) : CW'(head_row - 1'b1);
	assign e_row    = CW'(entry_q.row);
	assign e_col    = CW'(entry_q.col);
	assign e_down   = entry_q.row_last  ? '0 : CW'(e_row + 1'b1);
	assign e_left   = entry_q.col_first ? CW'(GRID_SIDE - 1) : CW'(e_col - 1'b1);
	assign e_right  = entry_q.col_last  ? '0 : CW'(e_col + 1'b1);

	// read ports: site row and up row first, then down row
	assign rd_a_en   = pop;
	assign rd_b_en   = pop || (state_q == ST_GATHER);
	assign rd_b_addr = (state_q == ST_FETCH) ? head_up : e_down;

	// local product: how many of the four neighbors agree with the site
	always_comb begin
		s_bit  = rd_a_q[e_col];
		eq_cnt = 3'(!(rd_a_q[e_left] ^ s_bit)) + 3'(!(rd_a_q[e_right] ^ s_bit))
			+ 3'(!(up_row_q[e_col] ^ s_bit)) + 3'(!(rd_b_q[e_col] ^ s_bit));
	end

	// metropolis decision
	always_comb begin
		is_trial = (entry_q.cmd == CMD_TRIAL);
		unique case (mode_q)
			MODE_FERRO: begin
				uphill   = (eq_cnt > 3'd2);
				big_step = (eq_cnt == 3'd4);
			end
			MODE_ANTI: begin
				uphill   = (eq_cnt < 3'd2);
				big_step = (eq_cnt == 3'd0);
			end
			default: begin
				uphill   = 1'b0;
				big_step = 1'b0;
			end
		endcase
		flip = is_trial
			&& (!uphill || (entry_q.draw < (big_step ? th_large_q : th_small_q)));
	end

	// running sums and counters after this item
	always_comb begin
		bond_nx  = bond_q;
		mag_nx   = mag_q;
		trial_nx = trial_q;
		sweep_nx = sweep_q;
		if (flip) begin
			bond_nx = BOND_W'(bond_q + BOND_W'(8) - BOND_W'({eq_cnt, 2'b00}));
			mag_nx  = s_bit ? MAG_W'(mag_q - MAG_W'(2)) : MAG_W'(mag_q + MAG_W'(2));
		end
		if (is_trial) begin
			if (trial_q == TC_W'(SITES - 1)) begin
				trial_nx = '0;
				sweep_nx = SWEEP_W'(sweep_q + 1'b1);
			end else begin
				trial_nx = TC_W'(trial_q + 1'b1);
			end
		end
	end

	// memory write: clearing pass or flipped site
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_row_q;
			mem_wdata = '1;
		end else begin
			mem_we    = exec_go && flip;
			mem_waddr = e_row;
			mem_wdata = rd_a_q ^ (GRID_SIDE'(1) << e_col);
		end
	end

	// spin memory, one row per word
	always_ff @(posedge clk) begin
		if (mem_we) begin
			spin_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_a_en) begin
			rd_a_q <= spin_mem[head_row];
		end
		if (rd_b_en) begin
			rd_b_q <= spin_mem[rd_b_addr];
		end
	end

	// work registers for the item in flight
	always_ff @(posedge clk) begin
		if (pop) begin
			entry_q <= head;
		end
		if (state_q == ST_GATHER) begin
			up_row_q <= rd_b_q;
		end
		if (exec_go) begin
			spin_out_q  <= s_bit ^ flip;
			flip_out_q  <= flip;
			bond_out_q  <= bond_nx[BOND_OUT_W-1:0];
			mag_out_q   <= mag_nx[MAG_OUT_W-1:0];
			sweep_out_q <= sweep_nx;
		end
	end

	// sequencer, lattice totals and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_row_q   <= '0;
			bond_q      <= BOND_W'(2 * SITES);
			mag_q       <= MAG_W'(SITES);
			trial_q     <= '0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_row_q <= CW'(clr_row_q + 1'b1);
					if (clr_row_q == CW'(GRID_SIDE - 1)) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					if (pop) begin
						state_q <= ST_GATHER;
					end
				end
				ST_GATHER: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= ST_FETCH;
					end
				end
			endcase
			if (exec_go) begin
				bond_q  <= bond_nx;
				mag_q   <= mag_nx;
				trial_q <= trial_nx;
				sweep_q <= sweep_nx;
			end
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_FERRO;
			th_small_q <= '0;
			th_large_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:     mode_q     <= cfg_data[MODE_W-1:0];
				REG_TH_SMALL: th_small_q <= cfg_data[DRAW_W-1:0];
				REG_TH_LARGE: th_large_q <= cfg_data[DRAW_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign spin_bit          = spin_out_q;
	assign flipped           = flip_out_q;
	assign bond_sum          = bond_out_q;
	assign magnetization_sum = mag_out_q;
	assign sweep_count       = sweep_out_q;

endmodule

/* rtl/ising_metropolis_lattice.sv */
// top level of the ising lattice block with metropolis single-spin updates
//
// Input channel (in_valid/in_ready) moves one command per transfer: a trial or
// a spin read at (row, col), with a 32-bit uniform draw. Coordinates past the
// side clamp. Output channel (out_valid/out_ready) returns one result per
// command: the spin after the command, the flip flag, bond and magnetization
// sums and the completed sweep count.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 coupling mode,
// 1 small threshold, 2 large threshold); write only while the block is idle.
// The front end clamps and classifies commands into a two-entry queue; the back
// end takes one command at a time through the fetch, gather and exec states:
// read site and up rows, read down row, decide and write back. It starts no new
// command until the last one is written back, set by the two read ports of the
// row-wide spin memory. After reset a clearing pass sets every spin to +1, one
// row per cycle; in_ready stays low meanwhile, config writes still land.
// When the receiver stalls, the result holds in the output register; the queue
// keeps taking commands until full, then in_ready drops.
module ising_metropolis_lattice #(
	parameter int GRID_SIDE = ism_pkg::GRID_SIDE_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ism_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ism_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  command,
	input  logic [ism_pkg::COORD_IN_W-1:0]        row,
	input  logic [ism_pkg::COORD_IN_W-1:0]        col,
	input  logic [ism_pkg::DRAW_W-1:0]            random_draw,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  spin_bit,
	output logic                                  flipped,
	output logic signed [ism_pkg::BOND_OUT_W-1:0] bond_sum,
	output logic signed [ism_pkg::MAG_OUT_W-1:0]  magnetization_sum,
	output logic [ism_pkg::SWEEP_W-1:0]           sweep_count
);
	import ism_pkg::*;

	logic       push;
	logic       pop;
	logic       clearing;
	ism_entry_t push_entry;
	ism_entry_t head;
	ism_qstat_t qstat;

	// clamp and classify
	ism_front #(
		.GRID_SIDE(GRID_SIDE)
	) u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.row         (row),
		.col         (col),
		.random_draw (random_draw),
		.clearing    (clearing),
		.qstat       (qstat),
		.push        (push),
		.push_entry  (push_entry)
	);

	// command queue
	ism_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// lattice update
	ism_back #(
		.GRID_SIDE(GRID_SIDE)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.head              (head),
		.qstat             (qstat),
		.pop               (pop),
		.clearing          (clearing),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.spin_bit          (spin_bit),
		.flipped           (flipped),
		.bond_sum          (bond_sum),
		.magnetization_sum (magnetization_sum),
		.sweep_count       (sweep_count)
	);

endmodule

/* rtl/ism_checker.sv */
// port-level checks of the ising lattice block and their binding
module ism_checker #(
	parameter int GRID_SIDE = ism_pkg::GRID_SIDE_DEF
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic                                  spin_bit,
	input logic                                  flipped,
	input logic signed [ism_pkg::BOND_OUT_W-1:0] bond_sum,
	input logic signed [ism_pkg::MAG_OUT_W-1:0]  magnetization_sum,
	input logic [ism_pkg::SWEEP_W-1:0]           sweep_count
);
	import ism_pkg::*;

	localparam int SITES = GRID_SIDE * GRID_SIDE;
	localparam logic [1:0] BOND_LOW = 2'((2 * SITES) % 4);
	localparam logic       MAG_LOW  = 1'(SITES % 2);

	// no result while reset is asserted
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// the clearing pass holds off input right after reset
	a_clear_blocks: assert property (@(posedge clk) $rose(arst_n) |-> !in_ready)
		else $error("input taken before the lattice was initialized");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(spin_bit) && $stable(flipped)
			&& $stable(bond_sum) && $stable(magnetization_sum) && $stable(sweep_count))
		else $error("stalled result changed");

	// flips move the sums in steps that keep their parity
	a_sum_parity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bond_sum[1:0] == BOND_LOW) && (magnetization_sum[0] == MAG_LOW))
		else $error("bond or magnetization sum off its lattice parity");

endmodule

bind ising_metropolis_lattice ism_checker #(.GRID_SIDE(GRID_SIDE)) u_ism_checker (.*);
